// File: hdl/opst_pkg.sv
package opst_pkg;

  localparam int STACK_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int DATA_W      = 32;
  localparam int IDX_W       = 12;
  localparam int HEIGHT_W    = 11;

  localparam logic [2:0] OP_PUSH   = 3'd0;
  localparam logic [2:0] OP_POP    = 3'd1;
  localparam logic [2:0] OP_PEEK   = 3'd2;
  localparam logic [2:0] OP_LOAD   = 3'd3;
  localparam logic [2:0] OP_STORE  = 3'd4;
  localparam logic [2:0] OP_ADJUST = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_UNDER = 2'd1;
  localparam logic [1:0] ST_OVER  = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  typedef struct packed {
    logic [2:0]                opcode;
    logic signed [DATA_W-1:0]  value;
    logic signed [IDX_W-1:0]   index;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0]  read_data;
    logic [1:0]                status;
    logic [HEIGHT_W-1:0]       height;
  } out_item_t;

  // Request from the controller to the stack RAM.
  typedef struct packed {
    logic                we;
    logic [ADDR_W-1:0]   waddr;
    logic [DATA_W-1:0]   wdata;
    logic [ADDR_W-1:0]   raddr;
  } mem_req_t;

endpackage

// File: hdl/opst_ram.sv
module opst_ram (
  input  logic                           clk,
  input  opst_pkg::mem_req_t             req,
  output logic [opst_pkg::DATA_W-1:0]    rdata
);
  import opst_pkg::*;

  logic [DATA_W-1:0] mem [STACK_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

// File: hdl/opst_ctrl.sv
module opst_ctrl (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  opst_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output opst_pkg::out_item_t            out_data,
  output opst_pkg::mem_req_t             mem_req,
  input  logic [opst_pkg::DATA_W-1:0]    mem_rdata
);
  import opst_pkg::*;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_READ  = 2'd2;

  localparam int NH_W = HEIGHT_W + 2;
  localparam logic signed [NH_W-1:0] NH_MAX = NH_W'(STACK_DEPTH);

  logic [1:0]          state, state_next;
  logic [HEIGHT_W-1:0] height, height_next;
  logic [ADDR_W-1:0]   clr_addr, clr_addr_next;
  logic [2:0]          pend_op, pend_op_next;
  logic                out_valid_next;
  out_item_t           out_data_next;
  logic                res_load;
  logic                accept;
  logic                full;
  logic                slot_ok;
  logic [HEIGHT_W-1:0] height_dec;
  logic signed [NH_W-1:0] new_height;

  assign in_ready   = (state == S_IDLE) && (!out_valid || out_ready);
  assign accept     = in_valid && in_ready;
  assign full       = (height >= HEIGHT_W'(STACK_DEPTH));
  assign height_dec = height - HEIGHT_W'(1);
  assign slot_ok    = !in_data.index[IDX_W-1] && (in_data.index[IDX_W-2:0] < height);
  assign new_height = $signed({2'b00, height})
                    + $signed({{(NH_W-IDX_W){in_data.index[IDX_W-1]}}, in_data.index});

  always_comb begin
    state_next    = state;
    height_next   = height;
    clr_addr_next = clr_addr;
    pend_op_next  = pend_op;
    res_load      = 1'b0;
    out_data_next = out_data;
    mem_req.we    = 1'b0;
    mem_req.waddr = height[ADDR_W-1:0];
    mem_req.wdata = in_data.value;
    mem_req.raddr = height_dec[ADDR_W-1:0];

    unique case (state)
      S_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = clr_addr;
        mem_req.wdata = '0;
        clr_addr_next = clr_addr + ADDR_W'(1);
        if (clr_addr == ADDR_W'(STACK_DEPTH - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          out_data_next.read_data = '0;
          out_data_next.status    = ST_OK;
          pend_op_next            = in_data.opcode;
          unique case (in_data.opcode) inside
            OP_PUSH: begin
              if (full) begin
                out_data_next.status = ST_OVER;
              end else begin
                mem_req.we  = 1'b1;
                height_next = height + HEIGHT_W'(1);
              end
            end
            OP_POP, OP_PEEK: begin
              if (height == '0) begin
                out_data_next.status = ST_UNDER;
              end else begin
                state_next = S_READ;
              end
            end
            OP_LOAD: begin
              if (!slot_ok) begin
                out_data_next.status = ST_RANGE;
              end else if (full) begin
                out_data_next.status = ST_OVER;
              end else begin
                mem_req.raddr = in_data.index[ADDR_W-1:0];
                state_next    = S_READ;
              end
            end
            OP_STORE: begin
              if (!slot_ok) begin
                out_data_next.status = ST_RANGE;
              end else begin
                mem_req.we    = 1'b1;
                mem_req.waddr = in_data.index[ADDR_W-1:0];
              end
            end
            OP_ADJUST: begin
              if (new_height[NH_W-1]) begin
                out_data_next.status = ST_UNDER;
              end else if (new_height > NH_MAX) begin
                out_data_next.status = ST_OVER;
              end else begin
                height_next = new_height[HEIGHT_W-1:0];
              end
            end
            default: begin
            end
          endcase
          out_data_next.height = height_next;
          res_load             = (state_next == S_IDLE);
        end
      end
      S_READ: begin
        res_load                = 1'b1;
        state_next              = S_IDLE;
        out_data_next.read_data = mem_rdata;
        out_data_next.status    = ST_OK;
        unique case (pend_op)
          OP_POP: begin
            height_next = height_dec;
          end
          OP_LOAD: begin
            mem_req.we    = 1'b1;
            mem_req.wdata = mem_rdata;
            height_next   = height + HEIGHT_W'(1);
          end
          default: begin
          end
        endcase
        out_data_next.height = height_next;
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_comb begin
    if (res_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      height    <= '0;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      height    <= height_next;
      clr_addr  <= clr_addr_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    pend_op  <= pend_op_next;
    out_data <= out_data_next;
  end

endmodule

// File: hdl/operand_stack_with_frame_access.sv
// Operand stack of 32-bit words for a stack virtual machine.
// Each input item carries an opcode (push, pop, peek, load slot, store slot,
// adjust height), a value and a signed index; each item produces exactly one
// output item with the word read, a status code and the stack height after
// the operation. A failed operation changes nothing and returns a zero word.
// Both channels use valid/ready; an item moves when valid and ready are high.
// The stack words live in one synchronous RAM with a registered read.
// Push, store, adjust, unused opcodes and failed operations finish in the
// idle state: the result is registered at the accepting edge. Pop, peek and
// load pass through a read state that waits for the RAM read data; a load
// there writes the word back on top of the stack. One item is in flight at
// a time: the next is taken only after the last result is registered.
// After reset the block sweeps the RAM to zero, one word per cycle, over all
// 1024 words; in_ready stays low during the sweep.
// The output register holds a result until out_ready; while it is full and
// not being taken, in_ready is low and no new item is accepted.
module operand_stack_with_frame_access (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  opst_pkg::in_item_t     in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output opst_pkg::out_item_t    out_data
);
  import opst_pkg::*;

  mem_req_t           mem_req;
  logic [DATA_W-1:0]  mem_rdata;

  // Height tracking, decode and the result register.
  opst_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

  // Stack storage; slot 0 is the bottom of the stack.
  opst_ram u_ram (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

`ifndef NO_ASSERTIONS
  // The reported height never exceeds the stack depth.
  a_height_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.height <= HEIGHT_W'(STACK_DEPTH))
    else $error("height beyond stack depth");

  // A failed operation never returns a word.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status != ST_OK) |-> out_data.read_data == '0)
    else $error("failed operation returned data");

  // A push is answered in the cycle after it is accepted, with ok or overflow.
  a_push_done: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_data.opcode == OP_PUSH) |=>
      (out_valid && (out_data.status == ST_OK || out_data.status == ST_OVER)))
    else $error("push result missing or wrong status");
`endif

endmodule

// File: tb/tb_operand_stack_with_frame_access.sv
module tb_operand_stack_with_frame_access;
  import opst_pkg::*;

  // Longest stretch without a transfer on either channel before the run is
  // declared hung. The post-reset RAM sweep is one such gap. After that, a gap
  // is at most one sender idle burst plus one receiver idle burst, plus the
  // read path.
  localparam int STALL_LIMIT = 4000;
  // Most mismatch lines printed. Later mismatches are still counted.
  localparam int REPORT_CAP  = 50;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  operand_stack_with_frame_access u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Shadow copy of the stack. It is updated when an item is accepted, so it
  // always reflects every item the block has taken so far.
  logic [DATA_W-1:0] shadow_words [STACK_DEPTH];
  int                shadow_height;

  out_item_t expected_results [$];
  int        error_count;
  int        stall_cycles;
  bit        idle_on;

  // Clock with a period of 8.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Works out the result of one stack operation and applies it to the shadow
  // stack. A failed operation leaves the shadow untouched and reads zero.
  function automatic out_item_t predict_stack_op(in_item_t op);
    out_item_t res;
    int        slot;
    int        new_height;
    slot = int'(op.index);
    res.read_data = '0;
    res.status    = ST_OK;
    case (op.opcode) inside
      OP_PUSH: begin
        if (shadow_height >= STACK_DEPTH) begin
          res.status = ST_OVER;
        end else begin
          shadow_words[shadow_height] = op.value;
          shadow_height++;
        end
      end
      OP_POP, OP_PEEK: begin
        if (shadow_height == 0) begin
          res.status = ST_UNDER;
        end else begin
          res.read_data = shadow_words[shadow_height-1];
          if (op.opcode == OP_POP) shadow_height--;
        end
      end
      OP_LOAD: begin
        // The slot check comes before the full check.
        if (slot < 0 || slot >= shadow_height) begin
          res.status = ST_RANGE;
        end else if (shadow_height >= STACK_DEPTH) begin
          res.status = ST_OVER;
        end else begin
          res.read_data = shadow_words[slot];
          shadow_words[shadow_height] = shadow_words[slot];
          shadow_height++;
        end
      end
      OP_STORE: begin
        if (slot < 0 || slot >= shadow_height) begin
          res.status = ST_RANGE;
        end else begin
          shadow_words[slot] = op.value;
        end
      end
      OP_ADJUST: begin
        // Memory is kept, so words that come back into the stack keep their
        // old contents.
        new_height = shadow_height + slot;
        if (new_height < 0) begin
          res.status = ST_UNDER;
        end else if (new_height > STACK_DEPTH) begin
          res.status = ST_OVER;
        end else begin
          shadow_height = new_height;
        end
      end
      default: begin
        // The two unused opcodes do nothing and report ok.
      end
    endcase
    res.height = shadow_height[HEIGHT_W-1:0];
    return res;
  endfunction

  function automatic in_item_t stack_op(logic [2:0] opcode, logic [DATA_W-1:0] value,
                                        int index);
    in_item_t op;
    op.opcode = opcode;
    op.value  = value;
    op.index  = index[IDX_W-1:0];
    return op;
  endfunction

  task automatic report_mismatch(string what, logic [DATA_W-1:0] got,
                                 logic [DATA_W-1:0] want);
    error_count++;
    if (error_count <= REPORT_CAP) begin
      $display("MISMATCH @%0t %s: got 0x%08h, expected 0x%08h", $time, what, got, want);
    end
  endtask

  // Sends one item. Inputs change only at the falling edge. When idling is on,
  // a random burst of idle cycles may come first. The expected result is
  // recorded at the rising edge where the item is accepted. Valid stays high
  // between back-to-back items, so it is never lowered and raised in one step.
  task automatic issue_stack_op(in_item_t op);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = op;
    do @(posedge clk); while (!in_ready);
    expected_results.push_back(predict_stack_op(op));
  endtask

  // Holds the sender off until every outstanding result has come back.
  task automatic wait_for_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
  endtask

  // Fresh stack: every read or indexed access has to fail, and the unused
  // opcodes must do nothing.
  task automatic test_empty_stack();
    issue_stack_op(stack_op(OP_POP,    32'h0, 0));
    issue_stack_op(stack_op(OP_PEEK,   32'h0, 0));
    issue_stack_op(stack_op(OP_LOAD,   32'h0, 0));
    issue_stack_op(stack_op(OP_STORE,  32'h1234_5678, 0));
    issue_stack_op(stack_op(OP_ADJUST, 32'h0, -1));
    issue_stack_op(stack_op(3'd6,      32'hffff_ffff, -1));
    issue_stack_op(stack_op(3'd7,      32'h8000_0000, 2047));
  endtask

  // Extreme words through push, peek, pop, load and store, with slot numbers
  // just inside and just outside the valid range.
  task automatic test_word_paths();
    issue_stack_op(stack_op(OP_PUSH,   32'h7fff_ffff, 0));
    issue_stack_op(stack_op(OP_PUSH,   32'h8000_0000, -2048));
    issue_stack_op(stack_op(OP_PUSH,   32'hffff_ffff, 2047));
    issue_stack_op(stack_op(OP_PEEK,   32'h0, 0));
    issue_stack_op(stack_op(OP_LOAD,   32'h0, 0));
    issue_stack_op(stack_op(OP_LOAD,   32'h0, 4));
    issue_stack_op(stack_op(OP_LOAD,   32'h0, -1));
    issue_stack_op(stack_op(OP_STORE,  32'h0, 3));
    issue_stack_op(stack_op(OP_STORE,  32'h0, -2048));
    issue_stack_op(stack_op(OP_POP,    32'h0, 0));
    issue_stack_op(stack_op(OP_ADJUST, 32'h0, -4));
  endtask

  // Drives the stack to full with a single adjust, then checks push, load and
  // adjust going past the top and an adjust going below the bottom.
  task automatic test_full_stack();
    issue_stack_op(stack_op(OP_ADJUST, 32'h0, STACK_DEPTH - shadow_height));
    issue_stack_op(stack_op(OP_PUSH,   32'h5a5a_5a5a, 0));
    issue_stack_op(stack_op(OP_LOAD,   32'h0, 0));
    issue_stack_op(stack_op(OP_LOAD,   32'h0, STACK_DEPTH));
    issue_stack_op(stack_op(OP_ADJUST, 32'h0, 1));
    issue_stack_op(stack_op(OP_ADJUST, 32'h0, 2047));
    issue_stack_op(stack_op(OP_STORE,  32'h0bad_cafe, STACK_DEPTH - 1));
    issue_stack_op(stack_op(OP_PEEK,   32'h0, 0));
    issue_stack_op(stack_op(OP_ADJUST, 32'h0, -2048));
    issue_stack_op(stack_op(OP_ADJUST, 32'h0, -STACK_DEPTH));
  endtask

  function automatic logic [DATA_W-1:0] random_word();
    case ($urandom_range(0, 19))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'h0;
      3:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // Slot numbers are mostly valid, with a bias toward the bottom and top of
  // the stack. The rest are just out of range or fully random 12-bit values.
  function automatic int random_slot();
    int pick;
    pick = $urandom_range(0, 99);
    if (shadow_height > 0 && pick < 75) begin
      if (pick < 10) return 0;
      if (pick < 20) return shadow_height - 1;
      return $urandom_range(0, shadow_height - 1);
    end
    if (pick < 85) return shadow_height;
    if (pick < 90) return -1;
    return $urandom_range(0, 4095) - 2048;
  endfunction

  // Height moves are mostly small steps. Now and then there is a jump to
  // exactly full or exactly empty, or a random 12-bit amount that usually
  // goes out of range.
  function automatic int random_shift();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 7) return $urandom_range(0, 16) - 8;
    if (pick == 7) return STACK_DEPTH - shadow_height;
    if (pick == 8) return -shadow_height;
    return $urandom_range(0, 4095) - 2048;
  endfunction

  // Mostly well-formed traffic: pushes and pops roughly balance, and loads
  // pull the height upward, so the stack wanders over its whole depth. Unused
  // opcodes and bad slots make up the noise.
  task automatic test_random_traffic(int count);
    int       pick;
    in_item_t op;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 24) begin
        op = stack_op(OP_PUSH, random_word(), $urandom_range(0, 4095));
      end else if (pick < 50) begin
        op = stack_op(OP_POP, random_word(), $urandom_range(0, 4095));
      end else if (pick < 58) begin
        op = stack_op(OP_PEEK, random_word(), $urandom_range(0, 4095));
      end else if (pick < 70) begin
        op = stack_op(OP_LOAD, random_word(), random_slot());
      end else if (pick < 84) begin
        op = stack_op(OP_STORE, random_word(), random_slot());
      end else if (pick < 96) begin
        op = stack_op(OP_ADJUST, random_word(), random_shift());
      end else begin
        op = stack_op(3'($urandom_range(6, 7)), random_word(), $urandom_range(0, 4095));
      end
      issue_stack_op(op);
    end
  endtask

  // Receiver side. out_ready drops for random bursts while idling is on, and
  // stays high otherwise. It changes only at the falling edge.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk);
      end
      out_ready = 1'b1;
    end
  end

  // Checks each result against the oldest expectation, field by field.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing expected", out_data.read_data, 32'h0);
      end else begin
        want = expected_results.pop_front();
        if (out_data.read_data !== want.read_data)
          report_mismatch("read_data", out_data.read_data, want.read_data);
        if (out_data.status !== want.status)
          report_mismatch("status", 32'(out_data.status), 32'(want.status));
        if (out_data.height !== want.height)
          report_mismatch("height", 32'(out_data.height), 32'(want.height));
      end
    end
  end

  // Watchdog: ends the run when nothing moves on either channel for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("operand_stack_with_frame_access verification failed");
      $finish;
    end
  end

  initial begin
    rst           = 1'b1;
    in_valid      = 1'b0;
    in_data       = '0;
    idle_on       = 1'b1;
    shadow_height = 0;
    foreach (shadow_words[i]) shadow_words[i] = '0;

    // Reset is held from the start and released at a falling edge. The block
    // then clears its RAM, and in_ready stays low until that is done.
    repeat (8) @(negedge clk);
    rst = 1'b0;

    test_empty_stack();
    test_word_paths();
    test_full_stack();
    wait_for_results();

    test_random_traffic(600);
    // The sender holds off here until the block has handed back every result.
    wait_for_results();
    test_random_traffic(300);
    wait_for_results();

    // Final stretch at full rate on both sides.
    idle_on = 1'b0;
    test_random_traffic(250);
    wait_for_results();
    repeat (8) @(posedge clk);

    if (error_count == 0 && expected_results.size() == 0) begin
      $display("operand_stack_with_frame_access verification clean");
    end else begin
      $display("operand_stack_with_frame_access verification failed");
    end
    $finish;
  end

endmodule
